// ===== rtl/core/totp_pkg.sv =====
// Shared types and constants for the TOTP HMAC-SHA1 generator.
// No dependencies.
package totp_pkg;
  localparam int KEY_BYTES_DEF = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PW_W = 30;
  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KLEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS = 3'd6;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_BLK_LOAD, ST_BLK_RUN, ST_BLK_ADD, ST_TRUNC, ST_MOD, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic [511:0] block;
    logic [159:0] h_in;
  } sha_req_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    if (r < 7'd20) return 32'h5A827999;
    else if (r < 7'd40) return 32'h6ED9EBA1;
    else if (r < 7'd60) return 32'h8F1BBCDC;
    else return 32'hCA62C1D6;
  endfunction
endpackage

// ===== rtl/core/totp_sha1_core.sv =====
// One SHA-1 compression, one round per cycle, 16-word schedule window.
// Depends on totp_pkg.
module totp_sha1_core import totp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sha_req_t req,
  output logic done,
  output logic [159:0] h_out
);
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [6:0] rnd;
  logic run;
  logic [31:0] f, t, wn;

  always_comb begin
    if (rnd < 7'd20) f = (b & c) | (~b & d);
    else if (rnd < 7'd40) f = b ^ c ^ d;
    else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    t = {a[26:0], a[31:27]} + f + e + round_k(rnd) + w[0];
    wn = w[13] ^ w[8] ^ w[2] ^ w[0];
    wn = {wn[30:0], wn[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      rnd <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        rnd <= '0;
      end else if (run) begin
        rnd <= rnd + 7'd1;
        if (rnd == 7'd79) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      for (int i = 0; i < 16; i++) w[i] <= req.block[511-32*i -: 32];
      {a, b, c, d, e} <= req.h_in;
      h_out <= req.h_in;
    end else if (run) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= t;
    end else if (done) begin
      h_out <= {h_out[159:128] + a, h_out[127:96] + b, h_out[95:64] + c,
                h_out[63:32] + d, h_out[31:0] + e};
    end
  end

  property p_done_once;
    @(posedge clk) disable iff (rst) done |=> !done;
  endproperty
  a_done_once: assert property (p_done_once) else $error("done held");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    run && rnd != 7'd79 |=> run) else $error("run dropped early");
  a_rnd_range: assert property (@(posedge clk) disable iff (rst) rnd <= 7'd80)
    else $error("round overflow");
endmodule

// ===== rtl/core/totp_hmac_sha1_generator.sv =====
// Top level: TOTP password from time, key and step. Depends on totp_pkg
// and totp_sha1_core.
// Sequence from the accepting edge to the password strobe: restoring division of
// the time by the step, four SHA-1 compressions, a truncation step, restoring
// modulo and the strobe.
// One item at a time; busy is high until the strobe ends, so no new
// transaction is accepted before then.
// Reset (synchronous) restores key 0, key length 20, step 30, six digits.
// The result strobe lasts one cycle and cannot be stalled.
module totp_hmac_sha1_generator import totp_pkg::*; #(
  parameter int KEY_BYTES = KEY_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [63:0] time_value,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic done,
  output logic [PW_W-1:0] password
);
  localparam int LIM = (KEY_BYTES > 32) ? 32 : KEY_BYTES;

  logic [63:0] key_word [4];
  logic [5:0] key_length;
  logic [31:0] step_seconds;
  logic [3:0] digit_count;

  state_t state, state_next;
  logic [63:0] quo;
  logic [32:0] rem;
  logic [6:0] cnt;
  logic [1:0] blk;
  logic [159:0] hacc, inner_h;
  logic [511:0] kpad;
  sha_req_t req;
  logic sha_done;
  logic [159:0] sha_h;
  logic [61:0] mrem;
  logic [29:0] modv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
      key_length <= 6'd20;
      step_seconds <= 32'd30;
      digit_count <= 4'd6;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_word[cfg_index[1:0]] <= cfg_data;
        REG_KLEN: key_length <= cfg_data[5:0];
        REG_STEP: step_seconds <= cfg_data[31:0];
        REG_DIGITS: digit_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    kpad = '0;
    for (int i = 0; i < 32; i++) begin
      if (i < LIM && i < int'(key_length))
        kpad[511-8*i -: 8] = key_word[i/8][63-8*(i%8) -: 8];
    end
  end

  logic [63:0] counter;
  assign counter = (step_seconds == '0) ? '1 : quo;

  always_comb begin
    req.start = (state == ST_BLK_LOAD);
    req.h_in = (blk[0] == 1'b0) ? {H0, H1, H2, H3, H4} : hacc;
    case (blk)
      2'd0: req.block = kpad ^ {64{8'h36}};
      2'd1: req.block = {counter, 8'h80, 376'd0, 64'd576};
      2'd2: req.block = kpad ^ {64{8'h5C}};
      default: req.block = {inner_h, 8'h80, 280'd0, 64'd672};
    endcase
  end

  totp_sha1_core u_sha (.clk(clk), .rst(rst), .req(req), .done(sha_done), .h_out(sha_h));

  logic [3:0] off;
  logic [159:0] dsh;
  assign off = hacc[3:0];
  assign dsh = hacc << (8 * off);
  always_comb begin
    case (digit_count)
      4'd0: modv = 30'd1;
      4'd1: modv = 30'd10;
      4'd2: modv = 30'd100;
      4'd3: modv = 30'd1000;
      4'd4: modv = 30'd10000;
      4'd5: modv = 30'd100000;
      4'd6: modv = 30'd1000000;
      4'd7: modv = 30'd10000000;
      4'd8: modv = 30'd100000000;
      default: modv = 30'd1000000000;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_DIV;
      ST_DIV: if (cnt == 7'd63) state_next = ST_BLK_LOAD;
      ST_BLK_LOAD: state_next = ST_BLK_RUN;
      ST_BLK_RUN: if (sha_done) state_next = ST_BLK_ADD;
      ST_BLK_ADD: state_next = (blk == 2'd3) ? ST_TRUNC : ST_BLK_LOAD;
      ST_TRUNC: state_next = ST_MOD;
      ST_MOD: if (cnt == 7'd31) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
    password = mrem[61:32];
  end

  logic [32:0] rs;
  logic [62:0] ms;
  assign rs = {rem[31:0], quo[63]};
  assign ms = {mrem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      blk <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin cnt <= '0; blk <= '0; end
        ST_DIV, ST_MOD: cnt <= (cnt == 7'd63 || (state == ST_MOD && cnt == 7'd31))
                               ? '0 : cnt + 7'd1;
        ST_BLK_ADD: blk <= blk + 2'd1;
        ST_TRUNC: cnt <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin quo <= time_value; rem <= '0; end
      ST_DIV: begin
        if (rs >= {1'b0, step_seconds}) begin
          rem <= rs - {1'b0, step_seconds};
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rs;
          quo <= {quo[62:0], 1'b0};
        end
      end
      ST_BLK_ADD: begin
        hacc <= sha_h;
        if (blk == 2'd1) inner_h <= sha_h;
      end
      ST_TRUNC: mrem <= {31'd0, dsh[158:128]};
      ST_MOD: begin
        if (ms[62:32] >= {1'b0, modv})
          mrem <= {ms[61:32] - modv, ms[31:0]};
        else
          mrem <= ms[61:0];
      end
      default: ;
    endcase
  end

  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("strobe outside transaction");
  a_idle_after: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after result");
  a_mod_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> password < modv) else $error("password out of range");
endmodule
